@@ rtl/assert_macros.svh @@
// assertion macros used by byte_frame_deframer_sum_check
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/bfd_pkg.sv @@
// types and constants of the byte frame deframer
`default_nettype none

package bfd_pkg;

    localparam int MAX_PAYLOAD_DEF = 64;

    localparam logic [7:0] PRE_FIRST  = 8'h5A;
    localparam logic [7:0] PRE_SECOND = 8'hA5;

    localparam logic [6:0] IDX_LEN     = 7'd1;
    localparam logic [6:0] IDX_SRC     = 7'd2;
    localparam logic [6:0] IDX_DST     = 7'd3;
    localparam logic [6:0] IDX_CMD     = 7'd4;
    localparam logic [6:0] IDX_ARG     = 7'd5;
    localparam logic [6:0] IDX_PAYLOAD = 7'd6;
    localparam logic [6:0] FRAME_EXTRA = 7'd7;

    typedef struct packed {
        logic [7:0] byte_in;
    } t_in_item;

    typedef struct packed {
        logic [6:0]  frame_len;
        logic [7:0]  src_addr;
        logic [7:0]  dst_addr;
        logic [7:0]  command;
        logic [7:0]  argument;
        logic [7:0]  payload_byte;
        logic [5:0]  payload_index;
        logic        payload_valid;
        logic        last;
        logic [15:0] bad_frame_count;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/bfd_chan_if.sv @@
// valid/ready channel carrying one beat of a given payload type
`default_nettype none

interface bfd_chan_if #(
    parameter type t_payload = logic [7:0]
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/byte_frame_deframer_sum_check.sv @@
// byte frame deframer with payload buffer and inverted-sum check
//
// i_in (sink, bfd_pkg::t_in_item): one received byte per beat.
// o_out (source, bfd_pkg::t_result): one beat per payload byte of a good
// frame, or one beat with payload_valid low for an empty payload; last
// marks the final beat of the frame.
// Bytes are taken one per cycle while the block is hunting or inside a
// frame. The payload sits in a 1-read/1-write buffer with registered read.
// After the second checksum byte of a good frame, i_in.ready stays low
// while the buffer drains. Each result passes a buffer read, then the
// output register; the next read is issued only once the output register
// is empty or being taken, so a new read can overlap the hand-off of the
// previous result. A bad frame does not hold the input.
// A stalled receiver holds the output register and the drain waits on it;
// the input reopens once the last read of the frame is issued.
// Reset (i_rst_n low, synchronous) returns to the preamble hunt, clears the
// bad-frame counter and empties the output register; no buffer clearing.
`default_nettype none

`include "assert_macros.svh"

module byte_frame_deframer_sum_check #(
    parameter int MAX_PAYLOAD = bfd_pkg::MAX_PAYLOAD_DEF
) (
    input  wire   i_clk,
    input  wire   i_rst_n,
    bfd_chan_if.sink   i_in,
    bfd_chan_if.source o_out
);

    localparam int         MemDepth = MAX_PAYLOAD;
    localparam int         Aw       = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam logic [7:0] MaxLen   = 8'(MAX_PAYLOAD);

    typedef enum logic [3:0] {
        ST_HUNT0 = 4'b0001,
        ST_HUNT1 = 4'b0010,
        ST_BODY  = 4'b0100,
        ST_DRAIN = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic [6:0]       r_cnt, n_cnt;
    logic [6:0]       r_exp, n_exp;
    logic [15:0]      r_sum, n_sum;
    logic [6:0]       r_len, n_len;
    logic [7:0]       r_src, n_src;
    logic [7:0]       r_dst, n_dst;
    logic [7:0]       r_cmd, n_cmd;
    logic [7:0]       r_arg, n_arg;
    logic [7:0]       r_chk_lo, n_chk_lo;
    logic [15:0]      r_bad, n_bad;
    logic [5:0]       r_rd_idx, n_rd_idx;
    logic             r_rd_pend, n_rd_pend;
    logic [5:0]       r_pend_idx, n_pend_idx;
    logic             r_pend_last, n_pend_last;
    logic [7:0]       r_mem_q;
    bfd_pkg::t_result r_out, n_out;
    logic             r_out_valid, n_out_valid;

    logic [7:0]       r_mem [MemDepth];

    logic             in_fire;
    logic             out_fire;
    logic [7:0]       b;
    logic [6:0]       idx;
    logic [15:0]      got;
    logic             mem_we;
    logic [Aw-1:0]    mem_waddr;
    logic             rd_en;
    logic             rd_last;
    logic [6:0]       wofs;

    assign i_in.ready  = (r_state != ST_DRAIN);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign in_fire   = i_in.valid && i_in.ready;
    assign out_fire  = r_out_valid && o_out.ready;
    assign b         = i_in.data.byte_in;
    assign idx       = r_cnt + 7'd1;
    assign got       = {b, r_chk_lo};
    assign wofs      = idx - bfd_pkg::IDX_PAYLOAD;
    assign mem_waddr = wofs[Aw-1:0];
    assign rd_last   = (r_len == 7'd0) || (({1'b0, r_rd_idx} + 7'd1) == r_len);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_exp       = r_exp;
        n_sum       = r_sum;
        n_len       = r_len;
        n_src       = r_src;
        n_dst       = r_dst;
        n_cmd       = r_cmd;
        n_arg       = r_arg;
        n_chk_lo    = r_chk_lo;
        n_bad       = r_bad;
        n_rd_idx    = r_rd_idx;
        n_rd_pend   = 1'b0;
        n_pend_idx  = r_pend_idx;
        n_pend_last = r_pend_last;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        mem_we      = 1'b0;
        rd_en       = 1'b0;

        if (in_fire) begin
            unique case (r_state)
                ST_HUNT1: begin
                    if (b == bfd_pkg::PRE_SECOND) begin
                        n_state = ST_BODY;
                        n_cnt   = 7'd0;
                        n_exp   = 7'd0;
                        n_sum   = 16'd0;
                    end else if (b != bfd_pkg::PRE_FIRST) begin
                        n_state = ST_HUNT0;
                    end
                end
                ST_BODY: begin
                    n_cnt = idx;
                    if (idx == bfd_pkg::IDX_LEN) begin
                        if (b > MaxLen) begin
                            n_state = ST_HUNT0;
                            n_cnt   = 7'd0;
                            n_exp   = 7'd0;
                        end else begin
                            n_len = b[6:0];
                            n_exp = bfd_pkg::FRAME_EXTRA + b[6:0];
                            n_sum = {8'h00, b};
                        end
                    end else if (idx < (r_exp - 7'd1)) begin
                        n_sum = r_sum + {8'h00, b};
                        unique case (idx)
                            bfd_pkg::IDX_SRC: n_src = b;
                            bfd_pkg::IDX_DST: n_dst = b;
                            bfd_pkg::IDX_CMD: n_cmd = b;
                            bfd_pkg::IDX_ARG: n_arg = b;
                            default:          mem_we = 1'b1;
                        endcase
                    end else if (idx == (r_exp - 7'd1)) begin
                        n_chk_lo = b;
                    end else begin
                        n_state = ST_HUNT0;
                        n_cnt   = 7'd0;
                        n_exp   = 7'd0;
                        if (got != ~r_sum) begin
                            n_bad = r_bad + 16'd1;
                        end else begin
                            n_state  = ST_DRAIN;
                            n_rd_idx = 6'd0;
                        end
                    end
                end
                ST_DRAIN: begin
                end
                default: begin
                    n_state = (b == bfd_pkg::PRE_FIRST) ? ST_HUNT1 : ST_HUNT0;
                end
            endcase
        end

        // buffer read; output register is free by the time the data lands
        if (r_state == ST_DRAIN && !r_rd_pend && (!r_out_valid || out_fire)) begin
            rd_en       = 1'b1;
            n_rd_pend   = 1'b1;
            n_pend_idx  = r_rd_idx;
            n_pend_last = rd_last;
            if (rd_last) begin
                n_state = ST_HUNT0;
            end else begin
                n_rd_idx = r_rd_idx + 6'd1;
            end
        end

        if (r_rd_pend) begin
            n_out_valid           = 1'b1;
            n_out.frame_len       = r_len;
            n_out.src_addr        = r_src;
            n_out.dst_addr        = r_dst;
            n_out.command         = r_cmd;
            n_out.argument        = r_arg;
            n_out.payload_valid   = (r_len != 7'd0);
            n_out.payload_byte    = (r_len != 7'd0) ? r_mem_q : 8'h00;
            n_out.payload_index   = (r_len != 7'd0) ? r_pend_idx : 6'd0;
            n_out.last            = r_pend_last;
            n_out.bad_frame_count = r_bad;
        end else if (out_fire) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_HUNT0;
            r_cnt       <= 7'd0;
            r_exp       <= 7'd0;
            r_bad       <= 16'd0;
            r_rd_idx    <= 6'd0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_exp       <= n_exp;
            r_bad       <= n_bad;
            r_rd_idx    <= n_rd_idx;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum       <= n_sum;
        r_len       <= n_len;
        r_src       <= n_src;
        r_dst       <= n_dst;
        r_cmd       <= n_cmd;
        r_arg       <= n_arg;
        r_chk_lo    <= n_chk_lo;
        r_pend_idx  <= n_pend_idx;
        r_pend_last <= n_pend_last;
        r_out       <= n_out;
    end

    // payload buffer: writes only in the frame body, reads only while draining
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= b;
        end
        if (rd_en) begin
            r_mem_q <= r_mem[r_rd_idx[Aw-1:0]];
        end
    end

    `ASSERT_IMPLIES(a_pend_out_free, i_clk, i_rst_n, r_rd_pend, !r_out_valid)
    `ASSERT_IMPLIES(a_last_ends_drain, i_clk, i_rst_n, r_rd_pend && r_pend_last,
        r_state != ST_DRAIN)
    `ASSERT_IMPLIES(a_empty_payload, i_clk, i_rst_n, r_out_valid && !r_out.payload_valid,
        r_out.payload_byte == 8'h00 && r_out.last)
    `ASSERT_NEXT(a_drain_closes_input, i_clk, i_rst_n,
        r_state == ST_BODY && n_state == ST_DRAIN, !i_in.ready)

endmodule

`default_nettype wire
